/* hw/rtl/assert_macros.svh */
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define CDQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Clocked check that also holds during reset.
`define CDQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/cdq_pkg.sv */
package cdq_pkg;

	localparam int OP_W     = 2;
	localparam int CLS_W    = 6;
	localparam int VAL_W    = 32;
	localparam int ST_W     = 2;
	localparam int ACT_W    = 7;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 32;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd0;
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd3;

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
	localparam logic [ST_W-1:0] ST_BADCLASS = 2'd3;

	// register index is paddr[2]
	localparam logic REG_ACTIVE_CLASSES = 1'b0;
	localparam logic [ACT_W-1:0] ACTIVE_RESET = 7'd64;

	// field write enables of the node memory
	typedef struct packed {
		logic value;
		logic next;
		logic prev;
	} node_we_t;

	typedef struct packed {
		logic take;
		logic give;
	} fl_ctrl_t;

endpackage

/* hw/rtl/multi_class_deque_bank_top.sv */
// Channel    Dir  Handshake           Payload
// s_*        in   s_tvalid/s_tready   tdata {push_value, class_index}, tuser operation
// m_*        out  m_tvalid/m_tready   tdata popped_value, tuser status
// apb        in   psel/penable        active_classes at address 0
//
// One transaction at a time: IDLE, DEC, DONE for a push into an empty class or an item
// that ends with bad class, full pool or empty deque; a push into a nonempty class adds
// LINK and a successful pop adds POP before DONE. A pop reads the class ends, then the
// end node; a push into a nonempty class writes the new node, then links the neighbor
// through the one write port. No clearing pass: the free list is tracked with a
// fresh-node mark, so the block takes input right after reset.
// A result waits in the output register; a later result holds in its done state
// until that register drains.
`include "assert_macros.svh"

module multi_class_deque_bank_top #(
	parameter int NUM_CLASSES = 64,
	parameter int POOL_DEPTH  = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [5:0] class_index, [37:6] push_value, [39:38] zero
	input  logic [cdq_pkg::S_DATA_W-1:0]  s_tdata,
	// [1:0] operation
	input  logic [cdq_pkg::OP_W-1:0]      s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [31:0] popped_value
	output logic [cdq_pkg::M_DATA_W-1:0]  m_tdata,
	// [1:0] status
	output logic [cdq_pkg::ST_W-1:0]      m_tuser,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cdq_pkg::APB_AW-1:0]    paddr,
	input  logic [cdq_pkg::APB_DW-1:0]    pwdata,
	output logic [cdq_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);
	import cdq_pkg::*;

	localparam int CAW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int PW  = $clog2(POOL_DEPTH);
	localparam int CW  = $clog2(POOL_DEPTH + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DEC  = 5'b00010,
		S_LINK = 5'b00100,
		S_POP  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q, state_d;

	logic [ACT_W-1:0] active_q;
	logic [NUM_CLASSES-1:0] nonempty_q;

	logic [OP_W-1:0]  op_q;
	logic [CLS_W-1:0] cls_q;
	logic [VAL_W-1:0] val_q;
	logic [PW-1:0]    h_q, t_q, node_q, link_addr_q;
	logic             link_back_q;
	logic [VAL_W-1:0] res_val_q;
	logic [ST_W-1:0]  res_st_q;
	logic [VAL_W-1:0] out_val_q;
	logic [ST_W-1:0]  out_st_q;
	logic             out_valid_q;

	logic             accept, cfg_wr, out_free;
	logic [CAW-1:0]   cidx;
	logic             bad, is_push, is_back, is_front_pop, ne, push_ok, pop_ok;

	logic [PW-1:0]    cm_head, cm_tail;
	logic             cm_we;
	logic [PW-1:0]    cm_wr_head, cm_wr_tail;

	logic             nm_re;
	logic [PW-1:0]    nm_raddr;
	logic [VAL_W-1:0] nm_value;
	logic [PW-1:0]    nm_next, nm_prev;
	node_we_t         nm_we;
	logic [PW-1:0]    nm_waddr, nm_wr_next, nm_wr_prev;

	fl_ctrl_t         fl_ctrl;
	logic [PW-1:0]    fl_head;
	logic [CW-1:0]    fl_count;
	logic             fl_empty;

	// ---------------------------------------------------------------- config
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE_CLASSES);
	assign prdata = (paddr[2] == REG_ACTIVE_CLASSES) ? APB_DW'(active_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (cfg_wr) begin
			active_q <= pwdata[ACT_W-1:0];
		end
	end

	// ---------------------------------------------------------------- decode
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign cidx    = CAW'(9'(cls_q));

	assign bad = ({1'b0, cls_q} >= active_q) || (9'(cls_q) >= 9'(NUM_CLASSES));
	assign is_push      = (op_q == OP_PUSH_BACK) || (op_q == OP_PUSH_FRONT);
	assign is_back      = (op_q == OP_PUSH_BACK);
	assign is_front_pop = (op_q == OP_POP_FRONT);
	assign ne           = nonempty_q[cidx];
	assign push_ok = (state_q == S_DEC) && !bad && is_push && !fl_empty;
	assign pop_ok  = (state_q == S_DEC) && !bad && !is_push && ne;

	// ---------------------------------------------------------------- class memory
	always_comb begin
		cm_we      = 1'b0;
		cm_wr_head = cm_head;
		cm_wr_tail = cm_tail;
		if (push_ok) begin
			cm_we = 1'b1;
			if (!ne) begin
				cm_wr_head = fl_head;
				cm_wr_tail = fl_head;
			end else if (is_back) begin
				cm_wr_tail = fl_head;
			end else begin
				cm_wr_head = fl_head;
			end
		end else if (state_q == S_POP) begin
			cm_we      = (h_q != t_q);
			cm_wr_head = is_front_pop ? nm_next : h_q;
			cm_wr_tail = is_front_pop ? t_q : nm_prev;
		end
	end

	cdq_class_mem #(
		.DEPTH (NUM_CLASSES),
		.AW    (CAW),
		.PW    (PW)
	) u_class_mem (
		.clk     (clk),
		.re      (accept),
		.raddr   (CAW'(9'(s_tdata[CLS_W-1:0]))),
		.rd_head (cm_head),
		.rd_tail (cm_tail),
		.we      (cm_we),
		.waddr   (cidx),
		.wr_head (cm_wr_head),
		.wr_tail (cm_wr_tail)
	);

	// ---------------------------------------------------------------- node memory
	// on accept read the free head (its next link); on a pop read the end node
	assign nm_re    = accept || pop_ok;
	assign nm_raddr = accept ? fl_head : (is_front_pop ? cm_head : cm_tail);

	always_comb begin
		nm_we      = '0;
		nm_waddr   = fl_head;
		nm_wr_next = ne ? cm_head : fl_head;
		nm_wr_prev = ne ? cm_tail : fl_head;
		if (push_ok) begin
			nm_we.value = 1'b1;
			nm_we.next  = !ne || !is_back;
			nm_we.prev  = !ne || is_back;
		end else if (state_q == S_LINK) begin
			nm_waddr   = link_addr_q;
			nm_we.next = link_back_q;
			nm_we.prev = !link_back_q;
			nm_wr_next = node_q;
			nm_wr_prev = node_q;
		end else if (state_q == S_POP) begin
			// freed node goes on top of the free stack
			nm_waddr   = node_q;
			nm_we.next = 1'b1;
			nm_wr_next = fl_head;
		end
	end

	cdq_node_mem #(
		.DEPTH (POOL_DEPTH),
		.PW    (PW),
		.VW    (VAL_W)
	) u_node_mem (
		.clk      (clk),
		.re       (nm_re),
		.raddr    (nm_raddr),
		.rd_value (nm_value),
		.rd_next  (nm_next),
		.rd_prev  (nm_prev),
		.we       (nm_we),
		.waddr    (nm_waddr),
		.wr_value (val_q),
		.wr_next  (nm_wr_next),
		.wr_prev  (nm_wr_prev)
	);

	// ---------------------------------------------------------------- free list
	assign fl_ctrl.take = push_ok;
	assign fl_ctrl.give = (state_q == S_POP);

	cdq_free_list #(
		.DEPTH (POOL_DEPTH),
		.PW    (PW),
		.CW    (CW)
	) u_free_list (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (fl_ctrl),
		.mem_next  (nm_next),
		.give_node (node_q),
		.head      (fl_head),
		.count     (fl_count),
		.empty     (fl_empty)
	);

	// ---------------------------------------------------------------- control
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_DEC;
			end
			S_DEC: begin
				if (push_ok && ne) state_d = S_LINK;
				else if (pop_ok)   state_d = S_POP;
				else               state_d = S_DONE;
			end
			S_LINK: state_d = S_DONE;
			S_POP:  state_d = S_DONE;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			nonempty_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push_ok) begin
				nonempty_q[cidx] <= 1'b1;
			end else if ((state_q == S_POP) && (h_q == t_q)) begin
				nonempty_q[cidx] <= 1'b0;
			end
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= s_tuser;
			cls_q <= s_tdata[CLS_W-1:0];
			val_q <= s_tdata[CLS_W +: VAL_W];
		end
		if (state_q == S_DEC) begin
			h_q         <= cm_head;
			t_q         <= cm_tail;
			node_q      <= is_push ? fl_head : (is_front_pop ? cm_head : cm_tail);
			link_addr_q <= is_back ? cm_tail : cm_head;
			link_back_q <= is_back;
			res_val_q   <= '0;
			if (bad)                  res_st_q <= ST_BADCLASS;
			else if (is_push && fl_empty) res_st_q <= ST_FULL;
			else if (!is_push && !ne)     res_st_q <= ST_EMPTY;
			else                          res_st_q <= ST_OK;
		end
		if (state_q == S_POP) begin
			res_val_q <= nm_value;
		end
		if ((state_q == S_DONE) && out_free) begin
			out_val_q <= res_val_q;
			out_st_q  <= res_st_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_val_q;
	assign m_tuser  = out_st_q;

	// ---------------------------------------------------------------- checks
	`CDQ_ASSERT(a_accept_dec, clk, arst_n, accept |=> (state_q == S_DEC), "accept did not decode")
	`CDQ_ASSERT(a_pop_frees, clk, arst_n, (state_q == S_POP) |=> (fl_count == $past(fl_count) + 1'b1), "pop did not free a node")
	`CDQ_ASSERT(a_push_takes, clk, arst_n, push_ok |=> (fl_count == $past(fl_count) - 1'b1), "push did not take a node")
	`CDQ_ASSERT(a_done_loads, clk, arst_n, ((state_q == S_DONE) && out_free) |=> (m_tvalid && (state_q == S_IDLE)), "result not loaded")
	`CDQ_ASSERT_ALWAYS(a_count_range, clk, (!arst_n || (fl_count <= CW'(POOL_DEPTH))), "free count overflow")

endmodule

/* hw/rtl/cdq_class_mem.sv */
module cdq_class_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int PW    = 10
) (
	input  logic          clk,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [PW-1:0] rd_head,
	output logic [PW-1:0] rd_tail,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [PW-1:0] wr_head,
	input  logic [PW-1:0] wr_tail
);
	logic [2*PW-1:0] mem [DEPTH];
	logic [2*PW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wr_head, wr_tail};
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	assign rd_head = rd_q[2*PW-1:PW];
	assign rd_tail = rd_q[PW-1:0];

endmodule

/* hw/rtl/cdq_node_mem.sv */
module cdq_node_mem #(
	parameter int DEPTH = 1024,
	parameter int PW    = 10,
	parameter int VW    = 32
) (
	input  logic                   clk,
	input  logic                   re,
	input  logic [PW-1:0]          raddr,
	output logic [VW-1:0]          rd_value,
	output logic [PW-1:0]          rd_next,
	output logic [PW-1:0]          rd_prev,
	input  cdq_pkg::node_we_t      we,
	input  logic [PW-1:0]          waddr,
	input  logic [VW-1:0]          wr_value,
	input  logic [PW-1:0]          wr_next,
	input  logic [PW-1:0]          wr_prev
);
	import cdq_pkg::*;

	localparam int EW = VW + 2*PW;

	// entry layout: {value, next, prev}, each field separately writable
	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we.value) begin
			mem[waddr][EW-1 -: VW] <= wr_value;
		end
		if (we.next) begin
			mem[waddr][2*PW-1 -: PW] <= wr_next;
		end
		if (we.prev) begin
			mem[waddr][PW-1:0] <= wr_prev;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	assign rd_value = rd_q[EW-1 -: VW];
	assign rd_next  = rd_q[2*PW-1 -: PW];
	assign rd_prev  = rd_q[PW-1:0];

endmodule

/* hw/rtl/cdq_free_list.sv */
module cdq_free_list #(
	parameter int DEPTH = 1024,
	parameter int PW    = 10,
	parameter int CW    = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cdq_pkg::fl_ctrl_t ctrl,
	input  logic [PW-1:0]     mem_next,
	input  logic [PW-1:0]     give_node,
	output logic [PW-1:0]     head,
	output logic [CW-1:0]     count,
	output logic              empty
);
	import cdq_pkg::*;

	logic [PW-1:0] head_q;
	logic [CW-1:0] count_q;
	// nodes at and above fresh_q were never taken: their next is i+1 (0 after the last), not read
	logic [CW-1:0] fresh_q;
	logic          head_fresh;
	logic [PW-1:0] fresh_next;

	assign head_fresh = CW'(head_q) >= fresh_q;
	assign fresh_next = (head_q == PW'(DEPTH - 1)) ? '0 : head_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= CW'(DEPTH);
			fresh_q <= '0;
		end else if (ctrl.take) begin
			head_q  <= head_fresh ? fresh_next : mem_next;
			count_q <= count_q - 1'b1;
			if (head_fresh) begin
				fresh_q <= fresh_q + 1'b1;
			end
		end else if (ctrl.give) begin
			head_q  <= give_node;
			count_q <= count_q + 1'b1;
		end
	end

	assign head  = head_q;
	assign count = count_q;
	assign empty = (count_q == '0);

endmodule
